### rtl/non_restoring_divider_defines.svh
// Assertion helpers for the divider.
`ifndef NON_RESTORING_DIVIDER_DEFINES_SVH
`define NON_RESTORING_DIVIDER_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while in reset.
`define NRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while in reset.
`define NRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nrd_pkg.sv
package nrd_pkg;

    localparam int FIELD_W = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } t_in;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               divide_by_zero;
    } t_out;

endpackage

### rtl/nrd_step.sv
// One non-restoring iteration followed by a pipeline register.
module nrd_step #(
    parameter int WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [WIDTH+1:0]   i_a,
    input  logic [WIDTH-1:0]   i_q,
    input  logic [WIDTH-1:0]   i_m,
    output logic               o_valid,
    output logic [WIDTH+1:0]   o_a,
    output logic [WIDTH-1:0]   o_q,
    output logic [WIDTH-1:0]   o_m
);
    localparam int AW = WIDTH + 2;

    logic          r_valid;
    logic [AW-1:0] r_a;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_m;

    logic [AW-1:0] n_a;
    logic [WIDTH-1:0] n_q;
    logic [AW-1:0] w_shift;
    logic [AW-1:0] w_m_ext;

    always_comb begin
        // shift A:Q left as one word
        w_shift = {i_a[AW-2:0], i_q[WIDTH-1]};
        w_m_ext = AW'(i_m);
        if (i_a[AW-1]) begin
            n_a = w_shift + w_m_ext;
        end else begin
            n_a = w_shift - w_m_ext;
        end
        n_q = {i_q[WIDTH-2:0], ~n_a[AW-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_q <= n_q;
            r_m <= i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_a     = r_a;
    assign o_q     = r_q;
    assign o_m     = r_m;
endmodule

### rtl/nrd_fix.sv
// Final remainder correction and output register.
module nrd_fix #(
    parameter int WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [WIDTH+1:0]   i_a,
    input  logic [WIDTH-1:0]   i_q,
    input  logic [WIDTH-1:0]   i_m,
    output logic               o_valid,
    output nrd_pkg::t_out      o_out
);
    import nrd_pkg::*;

    localparam int AW = WIDTH + 2;

    logic          r_valid;
    t_out          r_out;
    t_out          n_out;
    logic [AW-1:0] w_rem;

    always_comb begin
        // negative remainder gets the divisor added back
        w_rem = i_a[AW-1] ? (i_a + AW'(i_m)) : i_a;
        n_out.quotient       = FIELD_W'(i_q);
        n_out.remainder      = FIELD_W'(w_rem[WIDTH-1:0]);
        n_out.divide_by_zero = (i_m == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule

### rtl/non_restoring_divider.sv
// Pipeline: WIDTH + 1 register stages (one per quotient bit, plus the remainder
//   correction and output register); o_valid is driven by the output register.
// Throughput: one division per cycle while not stalled; every stage holds its own step adder.
// Stall: the whole pipeline freezes while a valid result waits under i_stall.
// Reset (i_rst_n low, synchronous): all stage valid bits clear; data is left as is.
`include "non_restoring_divider_defines.svh"

module non_restoring_divider #(
    parameter int WIDTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  nrd_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output nrd_pkg::t_out  o_out
);
    import nrd_pkg::*;

    localparam int AW = WIDTH + 2;
    // input bits at and above WIDTH are ignored
    localparam int IW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

    // Pipeline enable: everything advances unless the output register is
    // holding a result the sink has not taken.
    logic w_en;

    // Stage k carries A (sign-extended partial remainder), the shifting
    // dividend/quotient word and the divisor.  Entry 0 is the input side.
    logic             w_valid [0:WIDTH];
    logic [AW-1:0]    w_a     [0:WIDTH];
    logic [WIDTH-1:0] w_q     [0:WIDTH];
    logic [WIDTH-1:0] w_m     [0:WIDTH];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    assign w_valid[0] = i_valid;
    assign w_a[0]     = '0;
    assign w_q[0]     = WIDTH'(i_in.dividend[IW-1:0]);
    assign w_m[0]     = WIDTH'(i_in.divisor[IW-1:0]);

    // One step per stage: shift, then add or subtract by the sign of A.
    for (genvar k = 0; k < WIDTH; k++) begin : g_step
        nrd_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_a     (w_a[k]),
            .i_q     (w_q[k]),
            .i_m     (w_m[k]),
            .o_valid (w_valid[k+1]),
            .o_a     (w_a[k+1]),
            .o_q     (w_q[k+1]),
            .o_m     (w_m[k+1])
        );
    end

    // Remainder restore, zero-divisor flag and the output register.
    nrd_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[WIDTH]),
        .i_a     (w_a[WIDTH]),
        .i_q     (w_q[WIDTH]),
        .i_m     (w_m[WIDTH]),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // An input transfer lands in the first stage.
    `NRD_ASSERT_NEXT(a_enter, i_valid && !o_stall, w_valid[1], "input transfer lost")
    // A frozen pipeline keeps its last step occupancy.
    `NRD_ASSERT_NEXT(a_hold, !w_en, $stable(w_valid[WIDTH]) && o_valid, "moved while stalled")
    // Division by zero always yields an all-ones quotient.
    `NRD_ASSERT_NOW(a_dz, o_valid && o_out.divide_by_zero,
                    o_out.quotient == FIELD_W'({WIDTH{1'b1}}), "bad quotient on zero divisor")
endmodule

### verif/nrd_tb_pkg.sv
`timescale 1ns / 1ps

package nrd_tb_pkg;

    import nrd_pkg::*;

    class div_scoreboard;

        t_out        results_due[$];
        int unsigned mismatches;
        int unsigned unexpected;

        function new();
            mismatches = 0;
            unexpected = 0;
        endfunction

        // Non-restoring division on an 18-bit two's complement partial remainder.
        function t_out nr_divide(t_in operands);
            logic [FIELD_W-1:0] quo;
            logic [FIELD_W+1:0] part;
            logic [FIELD_W+1:0] dvs;
            logic               neg;
            t_out               res;
            quo  = operands.dividend;
            dvs  = {2'b00, operands.divisor};
            part = '0;
            for (int step = 0; step < FIELD_W; step++) begin
                neg  = part[FIELD_W+1];
                part = {part[FIELD_W:0], quo[FIELD_W-1]};
                quo  = quo << 1;
                if (!neg) begin
                    part = part - dvs;
                end else begin
                    part = part + dvs;
                end
                quo[0] = ~part[FIELD_W+1];
            end
            // negative remainder gets one restoring add
            if (part[FIELD_W+1]) begin
                part = part + dvs;
            end
            res.quotient       = quo;
            res.remainder      = part[FIELD_W-1:0];
            res.divide_by_zero = (operands.divisor == '0);
            return res;
        endfunction

        function void note_input(t_in operands);
            results_due.insert(results_due.size(), nr_divide(operands));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (results_due.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10) begin
                    $display("ERROR: result with nothing pending: q=%h r=%h dbz=%b",
                             got.quotient, got.remainder, got.divide_by_zero);
                end
                return;
            end
            want = results_due.pop_front();
            if (got.quotient != want.quotient || got.remainder != want.remainder ||
                got.divide_by_zero != want.divide_by_zero) begin
                mismatches++;
                if (mismatches + unexpected <= 10) begin
                    $display("ERROR: exp q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b",
                             want.quotient, want.remainder, want.divide_by_zero,
                             got.quotient, got.remainder, got.divide_by_zero);
                end
            end
        endfunction

        function int unsigned pending();
            return results_due.size();
        endfunction

    endclass

endpackage

### verif/non_restoring_divider_tb.sv
`timescale 1ns / 1ps

module non_restoring_divider_tb;

    import nrd_pkg::*;
    import nrd_tb_pkg::*;

    localparam int DIV_WIDTH   = 16;
    localparam int LATENCY     = DIV_WIDTH + 1;
    localparam int IDLE_PCT    = 31;
    localparam int NUM_RANDOM  = 1035;
    // no-idle window on both sides, in random item indexes
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 520;
    // receiver hold-off starts at this random item; HOLD_LEN sets how long it lasts
    localparam int HOLD_AT     = 360;
    localparam int HOLD_LEN    = 150;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_in;
    logic o_valid;
    logic i_stall;
    t_out o_out;

    // shared flags between the sender and receiver processes
    bit calm;
    bit hold_req;
    bit draining;

    int unsigned   cycle_count;
    div_scoreboard div_sb = new();

    non_restoring_divider #(
        .WIDTH(DIV_WIDTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: fails the run once cycle_count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: a transfer happens when o_valid is high and i_stall is low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            div_sb.check_result(o_out);
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    initial begin
        int hold_cycles;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // long hold-off so the pipeline fills and pushes back on the input
                i_stall <= 1'b1;
                for (hold_cycles = 1; hold_cycles < HOLD_LEN; hold_cycles++) begin
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end else if (calm || draining) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Offer one operand pair; entered just after a falling edge, returns just
    // after the falling edge that follows its transfer.
    task automatic send_operands(input t_in operands);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            i_in    <= t_in'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= operands;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        div_sb.note_input(operands);
        @(negedge i_clk);
    endtask

    // Random operands, weighted toward the interesting corners of division.
    function automatic t_in random_operands();
        t_in         operands;
        int unsigned pick;
        pick = $urandom_range(99);
        operands.dividend = FIELD_W'($urandom);
        if ($urandom_range(9) == 0) begin
            operands.dividend = FIELD_W'($urandom_range(0, 40));
        end
        if (pick < 6) begin
            operands.divisor = '0;
        end else if (pick < 28) begin
            operands.divisor = FIELD_W'($urandom_range(1, 15));
        end else if (pick < 42) begin
            operands.divisor = operands.dividend >> $urandom_range(0, FIELD_W - 1);
        end else if (pick < 54) begin
            // divisor right around the dividend: dividend - 1, dividend or dividend + 1
            operands.divisor = operands.dividend + FIELD_W'($urandom_range(0, 2))
                               - FIELD_W'(1);
        end else if (pick < 62) begin
            operands.divisor = FIELD_W'(16'hFFFF - $urandom_range(0, 3));
        end else begin
            operands.divisor = FIELD_W'($urandom);
        end
        return operands;
    endfunction

    initial begin
        t_in directed_set[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        draining = 1'b0;
        cycle_count = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, divide by zero, unit divisor, top-bit cases.
        directed_set = '{
            '{dividend: 16'h0000, divisor: 16'h0000},
            '{dividend: 16'hFFFF, divisor: 16'h0000},
            '{dividend: 16'h1234, divisor: 16'h0000},
            '{dividend: 16'hFFFF, divisor: 16'hFFFF},
            '{dividend: 16'hFFFF, divisor: 16'h0001},
            '{dividend: 16'h0000, divisor: 16'hFFFF},
            '{dividend: 16'h0000, divisor: 16'h0001},
            '{dividend: 16'h0001, divisor: 16'h0001},
            '{dividend: 16'h0001, divisor: 16'hFFFF},
            '{dividend: 16'hFFFE, divisor: 16'hFFFF},
            '{dividend: 16'h7FFF, divisor: 16'h8000},
            '{dividend: 16'h8000, divisor: 16'h7FFF},
            '{dividend: 16'hFFFF, divisor: 16'h8000},
            '{dividend: 16'h8000, divisor: 16'h0001},
            '{dividend: 16'h5555, divisor: 16'hAAAA},
            '{dividend: 16'hAAAA, divisor: 16'h5555},
            '{dividend: 16'h0100, divisor: 16'h0003},
            '{dividend: 16'hFFFF, divisor: 16'h0002},
            '{dividend: 16'hC000, divisor: 16'h0007}
        };
        foreach (directed_set[idx]) begin
            send_operands(directed_set[idx]);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
            end
            send_operands(random_operands());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // Drain, then watch a little longer for stray results.
        draining = 1'b1;
        while (div_sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4 * LATENCY) @(posedge i_clk);

        if (div_sb.mismatches == 0 && div_sb.unexpected == 0 && div_sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/nrd_pkg.sv
rtl/nrd_step.sv
rtl/nrd_fix.sv
rtl/non_restoring_divider.sv
verif/nrd_tb_pkg.sv
verif/non_restoring_divider_tb.sv
